// File: hdl/qbs_pkg.sv
package qbs_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned MAX_DEPTH   = 5;
  localparam int unsigned DEPTH_W     = 3;
  localparam int unsigned SKIP_W      = 4;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned LVL_W       = 3;
  localparam int unsigned STACK_DEPTH = (MAX_DEPTH > 2) ? MAX_DEPTH - 1 : 2;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP  = 1'd1;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd3;
  localparam logic [SKIP_W-1:0]  SKIP_RESET  = 4'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic                      in_last;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      run_last;
    logic                      stream_end;
  } out_rsp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    point_t p0;
    point_t p1;
    point_t p2;
  } triple_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } dp_op_e;

  typedef enum logic [1:0] {
    EM_A,
    EM_M3,
    EM_TOP,
    EM_C
  } emit_sel_e;

  typedef struct packed {
    logic             load;
    logic             hold_wr0;
    logic             hold_wr1;
    dp_op_e           op;
    logic [IDX_W-1:0] stk_wr_idx;
    logic [IDX_W-1:0] stk_rd_idx;
    logic             emit;
    emit_sel_e        emit_sel;
    logic             run_last;
    logic             stream_end;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // floor of the mean, exact over the full sum
  function automatic logic signed [COORD_W-1:0] mid_coord(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return s[COORD_W:1];
  endfunction

  function automatic point_t mid_pt(input point_t a, input point_t b);
    point_t r;
    r.x = mid_coord(a.x, b.x);
    r.y = mid_coord(a.y, b.y);
    return r;
  endfunction

endpackage

// File: hdl/quadratic_bezier_subdivider.sv
// channel   direction  payload     handshake
// in        request    in_req_t    in_valid_i / in_stall_o
// out       request    out_rsp_t   out_valid_o / out_stall_i
// cfg       write      4-bit data  cfg_we_i, cfg_idx_i
//
// a point that completes a curve emits its start point, the subdivision points
// and its end point, one more when the final point is repeated
// the subdivision stack makes one push or pop per cycle, a pop only while the output is free
// rst_ni clears state, depth to 3 and skip_count to 1
// a stalled output holds the sequencer; one result can wait while a request is taken
module quadratic_bezier_subdivider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  qbs_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output qbs_pkg::out_rsp_t             out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [qbs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [qbs_pkg::CFG_W-1:0]     cfg_wdata_i
);

  qbs_pkg::cmd_t cmd;
  qbs_pkg::sts_t sts;

  qbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_req_i.in_last),
    .in_stall_o  (in_stall_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: hdl/qbs_ctrl.sv
module qbs_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_last_i,
  output logic                             in_stall_o,
  input  logic                             cfg_we_i,
  input  logic [qbs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [qbs_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  qbs_pkg::sts_t                    sts_i,
  output qbs_pkg::cmd_t                    cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FIRST  = 2'd1;
  localparam logic [1:0] ST_SUBDIV = 2'd2;
  localparam logic [1:0] ST_EXTRA  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [qbs_pkg::DEPTH_W-1:0]  depth_q;
  logic [qbs_pkg::SKIP_W-1:0]   skip_q;
  logic [qbs_pkg::POS_W-1:0]    pos_q, pos_d;
  logic                         nz_q, nz_d;
  logic                         last_q, last_d;
  logic                         extra_q, extra_d;
  logic                         cur_valid_q, cur_valid_d;
  logic [qbs_pkg::LVL_W-1:0]    cur_lvl_q, cur_lvl_d;
  logic [qbs_pkg::SP_W-1:0]     sp_q, sp_d;
  logic [qbs_pkg::LVL_W-1:0]    lvl_stk_q [qbs_pkg::STACK_DEPTH];
  logic                         lvl_wr;

  logic [qbs_pkg::DEPTH_W-1:0]  dmax;
  logic [qbs_pkg::POS_W-1:0]    period;
  logic [qbs_pkg::POS_W-1:0]    pos_inc;
  logic [qbs_pkg::SP_W-1:0]     sp_m1;
  logic [qbs_pkg::LVL_W-1:0]    next_lvl;
  logic [qbs_pkg::LVL_W-1:0]    pop_lvl;
  logic                         curve;
  logic                         out_free;

  assign dmax     = (depth_q > qbs_pkg::DEPTH_W'(qbs_pkg::MAX_DEPTH))
                    ? qbs_pkg::DEPTH_W'(qbs_pkg::MAX_DEPTH) : depth_q;
  assign period   = qbs_pkg::POS_W'(skip_q) + qbs_pkg::POS_W'(2);
  assign pos_inc  = pos_q + qbs_pkg::POS_W'(1);
  assign sp_m1    = sp_q - qbs_pkg::SP_W'(1);
  assign next_lvl = cur_lvl_q + qbs_pkg::LVL_W'(1);
  assign pop_lvl  = lvl_stk_q[sp_m1[qbs_pkg::IDX_W-1:0]] + qbs_pkg::LVL_W'(1);
  assign curve    = (period == qbs_pkg::POS_W'(2)) ? ((pos_q == '0) && nz_q)
                                                   : (pos_q == qbs_pkg::POS_W'(2));
  assign out_free = sts_i.out_free;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    nz_d        = nz_q;
    last_d      = last_q;
    extra_d     = extra_q;
    cur_valid_d = cur_valid_q;
    cur_lvl_d   = cur_lvl_q;
    sp_d        = sp_q;
    lvl_wr      = 1'b0;
    cmd_o            = '0;
    cmd_o.op         = qbs_pkg::OP_NONE;
    cmd_o.emit_sel   = qbs_pkg::EM_A;
    cmd_o.stk_wr_idx = sp_q[qbs_pkg::IDX_W-1:0];
    cmd_o.stk_rd_idx = sp_m1[qbs_pkg::IDX_W-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.hold_wr0 = (pos_q == qbs_pkg::POS_W'(0));
          cmd_o.hold_wr1 = (pos_q == qbs_pkg::POS_W'(1));
          last_d      = in_last_i;
          extra_d     = in_last_i && (pos_q <= qbs_pkg::POS_W'(1));
          nz_d        = !in_last_i;
          if (in_last_i || (pos_inc >= period)) begin
            pos_d = '0;
          end else begin
            pos_d = pos_inc;
          end
          cur_valid_d = (dmax != '0);
          cur_lvl_d   = '0;
          sp_d        = '0;
          if (curve) begin
            state_d = ST_FIRST;
          end else if (in_last_i && (pos_q <= qbs_pkg::POS_W'(1))) begin
            state_d = ST_EXTRA;
          end
        end
      end
      ST_FIRST: begin
        if (out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = qbs_pkg::EM_A;
          state_d        = ST_SUBDIV;
        end
      end
      ST_SUBDIV: begin
        if (cur_valid_q) begin
          if (next_lvl < dmax) begin
            // descend left, park the right half
            cmd_o.op  = qbs_pkg::OP_PUSH;
            lvl_wr    = 1'b1;
            sp_d      = sp_q + qbs_pkg::SP_W'(1);
            cur_lvl_d = next_lvl;
          end else if (out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = qbs_pkg::EM_M3;
            cur_valid_d    = 1'b0;
          end
        end else if (sp_q != '0) begin
          if (out_free) begin
            cmd_o.op       = qbs_pkg::OP_POP;
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = qbs_pkg::EM_TOP;
            sp_d           = sp_m1;
            cur_lvl_d      = pop_lvl;
            cur_valid_d    = (pop_lvl < dmax);
          end
        end else if (out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_sel   = qbs_pkg::EM_C;
          cmd_o.run_last   = !extra_q;
          cmd_o.stream_end = last_q && !extra_q;
          state_d          = extra_q ? ST_EXTRA : ST_IDLE;
        end
      end
      ST_EXTRA: begin
        if (out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_sel   = qbs_pkg::EM_C;
          cmd_o.run_last   = 1'b1;
          cmd_o.stream_end = last_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= qbs_pkg::DEPTH_RESET;
      skip_q      <= qbs_pkg::SKIP_RESET;
      pos_q       <= '0;
      nz_q        <= 1'b0;
      last_q      <= 1'b0;
      extra_q     <= 1'b0;
      cur_valid_q <= 1'b0;
      cur_lvl_q   <= '0;
      sp_q        <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      nz_q        <= nz_d;
      last_q      <= last_d;
      extra_q     <= extra_d;
      cur_valid_q <= cur_valid_d;
      cur_lvl_q   <= cur_lvl_d;
      sp_q        <= sp_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          qbs_pkg::CFG_DEPTH: depth_q <= cfg_wdata_i[qbs_pkg::DEPTH_W-1:0];
          qbs_pkg::CFG_SKIP:  skip_q  <= cfg_wdata_i[qbs_pkg::SKIP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lvl_wr) begin
      lvl_stk_q[sp_q[qbs_pkg::IDX_W-1:0]] <= cur_lvl_q;
    end
  end

endmodule

// File: hdl/qbs_datapath.sv
module qbs_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qbs_pkg::in_req_t  in_req_i,
  input  qbs_pkg::cmd_t     cmd_i,
  output qbs_pkg::sts_t     sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qbs_pkg::out_rsp_t out_rsp_o
);

  qbs_pkg::point_t  a_q, b_q, c_q;
  qbs_pkg::point_t  held_q [2];
  qbs_pkg::triple_t stk_q [qbs_pkg::STACK_DEPTH];
  qbs_pkg::point_t  in_pt;
  qbs_pkg::point_t  m1, m2, m3;
  qbs_pkg::triple_t top;
  qbs_pkg::point_t  emit_pt;
  logic             out_valid_q;
  qbs_pkg::out_rsp_t out_q;

  assign in_pt.x = in_req_i.in_x;
  assign in_pt.y = in_req_i.in_y;
  assign m1  = qbs_pkg::mid_pt(a_q, b_q);
  assign m2  = qbs_pkg::mid_pt(b_q, c_q);
  assign m3  = qbs_pkg::mid_pt(m1, m2);
  assign top = stk_q[cmd_i.stk_rd_idx];

  always_comb begin
    case (cmd_i.emit_sel)
      qbs_pkg::EM_A:   emit_pt = a_q;
      qbs_pkg::EM_M3:  emit_pt = m3;
      qbs_pkg::EM_TOP: emit_pt = top.p0;
      qbs_pkg::EM_C:   emit_pt = c_q;
      default:         emit_pt = c_q;
    endcase
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_rsp_o      = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q[0]   <= '0;
      held_q[1]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.hold_wr0) begin
        held_q[0] <= in_pt;
      end
      if (cmd_i.hold_wr1) begin
        held_q[1] <= in_pt;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= held_q[0];
      b_q <= held_q[1];
      c_q <= in_pt;
    end else begin
      case (cmd_i.op)
        qbs_pkg::OP_PUSH: begin
          stk_q[cmd_i.stk_wr_idx] <= '{p0: m3, p1: m2, p2: c_q};
          b_q <= m1;
          c_q <= m3;
        end
        qbs_pkg::OP_POP: begin
          a_q <= top.p0;
          b_q <= top.p1;
          c_q <= top.p2;
        end
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      out_q.out_x      <= emit_pt.x;
      out_q.out_y      <= emit_pt.y;
      out_q.run_last   <= cmd_i.run_last;
      out_q.stream_end <= cmd_i.stream_end;
    end
  end

endmodule

// File: hdl/qbs_checker.sv
module qbs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input qbs_pkg::out_rsp_t             out_rsp_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // end of stream closes a run
  a_end_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_rsp_o.stream_end || out_rsp_o.run_last))
    else $error("stream_end without run_last");

  // no result while reset is held
  a_no_out_during_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // no new result in the cycle right after a request is taken
  a_out_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o || $past(out_valid_o) || in_stall_o)
    else $error("result appeared one cycle after a request");

endmodule

bind quadratic_bezier_subdivider qbs_checker u_qbs_checker (.*);

// File: dv/qbs_tb_pkg.sv
package qbs_tb_pkg;
  import qbs_pkg::*;

  class curve_scoreboard;
    logic [DEPTH_W-1:0] depth;
    logic [SKIP_W-1:0]  skip_count;
    point_t             held [2];
    int unsigned        group_pos;
    bit                 seen_point;
    point_t             pts [$];
    out_rsp_t           expected [$];
    int unsigned        mismatches;

    function new();
      depth      = DEPTH_RESET;
      skip_count = SKIP_RESET;
      held[0]    = '0;
      held[1]    = '0;
      group_pos  = 0;
      seen_point = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_DEPTH) begin
        depth = value[DEPTH_W-1:0];
      end else if (idx == CFG_SKIP) begin
        skip_count = value[SKIP_W-1:0];
      end
    endfunction

    function void add_point(point_t p);
      pts.insert(pts.size(), p);
    endfunction

    // floor of the mean, sum kept at 64 bits
    function logic signed [COORD_W-1:0] halfway(logic signed [COORD_W-1:0] a,
                                                logic signed [COORD_W-1:0] b);
      longint total;
      total = longint'(a) + longint'(b);
      return COORD_W'(total >>> 1);
    endfunction

    function void subdivide(int unsigned lvl, int unsigned lvl_max,
                            point_t a, point_t b, point_t c);
      point_t ab;
      point_t bc;
      point_t center;
      if (lvl >= lvl_max) return;
      ab.x     = halfway(a.x, b.x);
      ab.y     = halfway(a.y, b.y);
      bc.x     = halfway(b.x, c.x);
      bc.y     = halfway(b.y, c.y);
      center.x = halfway(ab.x, bc.x);
      center.y = halfway(ab.y, bc.y);
      subdivide(lvl + 1, lvl_max, a, ab, center);
      add_point(center);
      subdivide(lvl + 1, lvl_max, center, bc, c);
    endfunction

    function void note_request(in_req_t req);
      int unsigned period;
      int unsigned lvl_max;
      bit          curve;
      point_t      here;
      out_rsp_t    rsp;
      here.x  = req.in_x;
      here.y  = req.in_y;
      period  = 2 + skip_count;
      lvl_max = (depth > MAX_DEPTH) ? MAX_DEPTH : depth;
      curve   = (period == 2) ? (group_pos == 0 && seen_point) : (group_pos == 2);
      pts.delete();
      if (curve) begin
        add_point(held[0]);
        subdivide(0, lvl_max, held[0], held[1], here);
        add_point(here);
      end
      if (group_pos == 0) begin
        held[0] = here;
      end else if (group_pos == 1) begin
        held[1] = here;
      end
      if (req.in_last && group_pos <= 1) add_point(here);
      foreach (pts[i]) begin
        rsp.out_x      = pts[i].x;
        rsp.out_y      = pts[i].y;
        rsp.run_last   = (i == pts.size() - 1);
        rsp.stream_end = rsp.run_last && req.in_last;
        expected.insert(expected.size(), rsp);
      end
      if (req.in_last) begin
        group_pos  = 0;
        seen_point = 1'b0;
      end else begin
        group_pos  = (group_pos + 1 >= period) ? 0 : group_pos + 1;
        seen_point = 1'b1;
      end
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t want;
      if (expected.size() == 0) begin
        $error("unexpected result: out_x %0d out_y %0d", got.out_x, got.out_y);
        mismatches++;
        return;
      end
      want = expected.pop_front();
      if (got.out_x !== want.out_x) begin
        $error("out_x: expected %0d, actual %0d", want.out_x, got.out_x);
        mismatches++;
      end
      if (got.out_y !== want.out_y) begin
        $error("out_y: expected %0d, actual %0d", want.out_y, got.out_y);
        mismatches++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
        mismatches++;
      end
      if (got.stream_end !== want.stream_end) begin
        $error("stream_end: expected %0b, actual %0b", want.stream_end, got.stream_end);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qbs_pkg::*;
  import qbs_tb_pkg::*;

  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned RANDOM_PHASES = 9;
  localparam int unsigned PHASE_ITEMS   = 23;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_req_t              in_req    = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_rsp_t             out_rsp;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_DEPTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  bit long_hold_pending = 1'b0;

  curve_scoreboard sb = new();

  quadratic_bezier_subdivider u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int unsigned idle_span(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 6))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return COORD_W'(int'($urandom_range(0, 1023)) - 512);
      3: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_req_t pt(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                 logic last);
    in_req_t req;
    req.in_x    = x;
    req.in_y    = y;
    req.in_last = last;
    return req;
  endfunction

  task automatic offer_point(in_req_t req, int unsigned gap);
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // wait until every request has produced its results and the block is quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [DEPTH_W-1:0] depth, logic [SKIP_W-1:0] skip);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DEPTH;
    cfg_wdata <= CFG_W'(depth);
    @(negedge clk);
    cfg_idx   <= CFG_SKIP;
    cfg_wdata <= CFG_W'(skip);
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_register(CFG_DEPTH, CFG_W'(depth));
    sb.set_register(CFG_SKIP, CFG_W'(skip));
  endtask

  initial begin : receiver
    int unsigned stall_left;
    int unsigned tick;
    bit          quiet;
    bit          long_done;
    stall_left = 0;
    tick       = 0;
    quiet      = 1'b0;
    long_done  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (long_hold_pending && !long_done) begin
        long_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_span(quiet);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_rsp);
  end

  initial begin : stimulus
    int unsigned        sent;
    int unsigned        run_left;
    bit                 tx_quiet;
    logic [DEPTH_W-1:0] depth;
    logic [SKIP_W-1:0]  skip;
    run_left = 0;
    tx_quiet = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: depth 3, period 3
    offer_point(pt(COORD_MAX, COORD_MIN, 1'b0), 0);
    offer_point(pt(COORD_MIN, COORD_MAX, 1'b0), 0);
    offer_point(pt('1, '0, 1'b0), 0);
    offer_point(pt('0, '1, 1'b0), 0);
    offer_point(pt(COORD_MAX, COORD_MAX, 1'b1), 0);
    offer_point(pt(COORD_MIN, COORD_MIN, 1'b1), 0);

    // depth above the maximum, period 5, leave the stream open at position 4
    configure(3'd7, 4'd3);
    offer_point(pt(32'sh0000_0100, 32'sh0000_0200, 1'b0), 0);
    offer_point(pt(32'sh5555_5555, 32'shAAAA_AAAA, 1'b0), 0);
    offer_point(pt(32'shAAAA_AAAA, 32'sh5555_5555, 1'b0), 0);
    offer_point(pt(-32'sd3, 32'sd3, 1'b0), 0);

    // period shrinks to 2 mid-stream, depth 0, final point completes a curve
    configure(3'd0, 4'd0);
    offer_point(pt(32'sd7, -32'sd7, 1'b0), 0);
    offer_point(pt(COORD_MAX, COORD_MIN, 1'b0), 0);
    offer_point(pt(-32'sd1, 32'sd1, 1'b0), 0);
    offer_point(pt(COORD_MIN, COORD_MAX, 1'b1), 0);

    // depth 5, period 4, final point with no output
    configure(3'd5, 4'd2);
    offer_point(pt(COORD_MIN, COORD_MIN, 1'b0), 0);
    offer_point(pt(COORD_MAX, COORD_MAX, 1'b0), 0);
    offer_point(pt(COORD_MIN, COORD_MAX, 1'b0), 0);
    offer_point(pt(32'sd11, 32'sd13, 1'b1), 0);

    // longest period, depth 1
    configure(3'd1, 4'd15);
    offer_point(pt(32'sh1234_5678, -32'sh1234_5678, 1'b0), 0);
    offer_point(pt(-32'sd255, 32'sd256, 1'b0), 0);
    offer_point(pt(32'sh7654_3210, 32'sh0FED_CBA9, 1'b0), 0);
    offer_point(pt(32'sd1, 32'sd2, 1'b1), 0);

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      depth = ($urandom_range(0, 9) < 7) ? DEPTH_W'($urandom_range(0, 3))
                                         : DEPTH_W'($urandom_range(4, 7));
      case ($urandom_range(0, 4))
        0: skip = '0;
        1: skip = '1;
        default: skip = SKIP_W'($urandom_range(0, 3));
      endcase
      configure(depth, skip);
      if (ph == 1) long_hold_pending = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (run_left == 0) begin
          if ($urandom_range(0, 4) == 0) begin
            run_left = $urandom_range(1, 3);
          end else begin
            run_left = $urandom_range(3, 3 * (2 + sb.skip_count) + 2);
          end
          tx_quiet = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        offer_point(pt(rand_coord(), rand_coord(), run_left == 0), idle_span(tx_quiet));
        sent++;
      end
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
